[rtl/ltcs_pkg.sv]
// Shared types and constants for the linear threshold classifier scorer.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package ltcs_pkg;

  localparam int NUM_CH_MAX = 7;
  localparam int TEMP_W     = 15;
  localparam int GAIN_W     = 10;
  localparam int BIAS_W     = 19;
  localparam int PROD_W     = GAIN_W + TEMP_W + 1;
  // 100*bias plus seven full-scale products stays inside 29 signed bits
  localparam int SUM_W      = 29;
  localparam int ICE_LIMIT  = 38002;
  localparam int BIAS_SCALE = 100;
  localparam int OUT_CNT_W  = 24;
  localparam int NUM_W      = 30;
  localparam int NUM_MAX    = 536870911;
  localparam int NUM_MIN    = -536870912;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [2:0] REG_BIAS        = 3'd0;
  localparam logic [2:0] REG_GAIN_ONE    = 3'd1;
  localparam logic [2:0] REG_GAIN_TWO    = 3'd2;
  localparam logic [2:0] REG_GAIN_THREE  = 3'd3;
  localparam logic [2:0] REG_GAIN_FOUR   = 3'd4;
  localparam logic [2:0] REG_GAIN_FIVE   = 3'd5;
  localparam logic [2:0] REG_GAIN_SIX    = 3'd6;
  localparam logic [2:0] REG_GAIN_SEVEN  = 3'd7;

  typedef enum logic [1:0] {
    DEC_UNSURE = 2'd0,
    DEC_ICE    = 2'd1,
    DEC_WATER  = 2'd2
  } decision_e;

  typedef struct packed {
    logic signed [BIAS_W-1:0]                     bias;
    logic        [NUM_CH_MAX-1:0][GAIN_W-1:0]     gain;
  } cfg_t;

  typedef struct packed {
    logic [NUM_CH_MAX-1:0][TEMP_W-1:0] temp;
    logic                              ice;
    logic                              last;
  } item_t;

endpackage

[rtl/linear_threshold_classifier_scorer_top.sv]
// Top level of the linear threshold classifier scorer: register port, chain of MAC
// cells, tally stage and output stage. Uses ltcs_pkg and ltcs_* but the checker.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one beat per item: seven
//   temperatures, the ice_present label and last_item. Output channel
//   (out_valid_o/out_ready_i) returns one beat per item with the decision;
//   on the beat of a last item it also carries the confusion tallies, the
//   item count and the score numerator with tallies_valid_o set, and the
//   tallies restart from zero. Other beats carry zero tallies.
//   From input beat to output beat an item passes one cell per channel, one
//   tally stage and one output stage. Throughput is one item per cycle when
//   not stalled; each cell owns one multiplier and passes its partial sum on.
//   When the receiver stalls, the whole chain holds in place and in_ready_o
//   drops; a beat still enters while the output register is being drained.
//   Reset clears the registers, the tallies and all valid flags.
//   Write bias at byte address 0 and gains one to seven at 4 to 28 while no
//   item is in flight.
`timescale 1ns / 1ps

module linear_threshold_classifier_scorer_top #(
  parameter int COUNT_BITS = 24,
  parameter int CHANNELS   = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ltcs_pkg::ADDR_W-1:0]         paddr,
  input  logic [ltcs_pkg::DATA_W-1:0]         pwdata,
  output logic [ltcs_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ltcs_pkg::TEMP_W-1:0]         temp_one_i,
  input  logic [ltcs_pkg::TEMP_W-1:0]         temp_two_i,
  input  logic [ltcs_pkg::TEMP_W-1:0]         temp_three_i,
  input  logic [ltcs_pkg::TEMP_W-1:0]         temp_four_i,
  input  logic [ltcs_pkg::TEMP_W-1:0]         temp_five_i,
  input  logic [ltcs_pkg::TEMP_W-1:0]         temp_six_i,
  input  logic [ltcs_pkg::TEMP_W-1:0]         temp_seven_i,
  input  logic                                ice_present_i,
  input  logic                                last_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          decision_o,
  output logic [ltcs_pkg::OUT_CNT_W-1:0]      ice_correct_o,
  output logic [ltcs_pkg::OUT_CNT_W-1:0]      ice_missed_o,
  output logic [ltcs_pkg::OUT_CNT_W-1:0]      water_correct_o,
  output logic [ltcs_pkg::OUT_CNT_W-1:0]      false_ice_o,
  output logic [ltcs_pkg::OUT_CNT_W-1:0]      item_total_o,
  output logic signed [ltcs_pkg::NUM_W-1:0]   score_numerator_o,
  output logic                                tallies_valid_o
);

  ltcs_pkg::cfg_t                             cfg;
  logic                                       adv;
  logic [CHANNELS:0]                          ch_valid;
  logic signed [CHANNELS:0][ltcs_pkg::SUM_W-1:0] ch_sum;
  ltcs_pkg::item_t [CHANNELS:0]               ch_item;

  logic                                       t_valid, t_last;
  logic [1:0]                                 t_dec;
  logic [4:0][ltcs_pkg::OUT_CNT_W-1:0]        t_cnt, o_cnt;
  logic [COUNT_BITS:0]                        t_correct, t_wrong;

  ltcs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // advance whenever the output register is free or being drained
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  assign ch_valid[0]     = in_valid_i;
  assign ch_sum[0]       = ltcs_pkg::SUM_W'($signed(cfg.bias) * ltcs_pkg::BIAS_SCALE);
  assign ch_item[0].temp = {temp_seven_i, temp_six_i, temp_five_i, temp_four_i,
                            temp_three_i, temp_two_i, temp_one_i};
  assign ch_item[0].ice  = ice_present_i;
  assign ch_item[0].last = last_item_i;

  for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
    ltcs_cell #(.IDX(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .gain_i  (cfg.gain[k]),
      .valid_i (ch_valid[k]),
      .sum_i   (ch_sum[k]),
      .item_i  (ch_item[k]),
      .valid_o (ch_valid[k+1]),
      .sum_o   (ch_sum[k+1]),
      .item_o  (ch_item[k+1])
    );
  end

  ltcs_tally #(.COUNT_BITS(COUNT_BITS)) u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (ch_valid[CHANNELS]),
    .sum_i      (ch_sum[CHANNELS]),
    .ice_i      (ch_item[CHANNELS].ice),
    .last_i     (ch_item[CHANNELS].last),
    .valid_o    (t_valid),
    .decision_o (t_dec),
    .last_o     (t_last),
    .cnt_o      (t_cnt),
    .correct_o  (t_correct),
    .wrong_o    (t_wrong)
  );

  ltcs_score #(.COUNT_BITS(COUNT_BITS)) u_score (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (t_valid),
    .decision_i      (t_dec),
    .last_i          (t_last),
    .cnt_i           (t_cnt),
    .correct_i       (t_correct),
    .wrong_i         (t_wrong),
    .valid_o         (out_valid_o),
    .decision_o      (decision_o),
    .cnt_o           (o_cnt),
    .num_o           (score_numerator_o),
    .tallies_valid_o (tallies_valid_o)
  );

  assign ice_correct_o   = o_cnt[0];
  assign ice_missed_o    = o_cnt[1];
  assign water_correct_o = o_cnt[2];
  assign false_ice_o     = o_cnt[3];
  assign item_total_o    = o_cnt[4];

endmodule

[rtl/ltcs_regs.sv]
// APB-style configuration registers: bias and the seven channel gains.
// Depends on ltcs_pkg for register codes and the cfg_t bundle.
`timescale 1ns / 1ps

module ltcs_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ltcs_pkg::ADDR_W-1:0]   paddr,
  input  logic [ltcs_pkg::DATA_W-1:0]   pwdata,
  output logic [ltcs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output ltcs_pkg::cfg_t                cfg_o
);

  ltcs_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[ltcs_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        ltcs_pkg::REG_BIAS:       cfg_d.bias    = pwdata[ltcs_pkg::BIAS_W-1:0];
        ltcs_pkg::REG_GAIN_ONE:   cfg_d.gain[0] = pwdata[ltcs_pkg::GAIN_W-1:0];
        ltcs_pkg::REG_GAIN_TWO:   cfg_d.gain[1] = pwdata[ltcs_pkg::GAIN_W-1:0];
        ltcs_pkg::REG_GAIN_THREE: cfg_d.gain[2] = pwdata[ltcs_pkg::GAIN_W-1:0];
        ltcs_pkg::REG_GAIN_FOUR:  cfg_d.gain[3] = pwdata[ltcs_pkg::GAIN_W-1:0];
        ltcs_pkg::REG_GAIN_FIVE:  cfg_d.gain[4] = pwdata[ltcs_pkg::GAIN_W-1:0];
        ltcs_pkg::REG_GAIN_SIX:   cfg_d.gain[5] = pwdata[ltcs_pkg::GAIN_W-1:0];
        ltcs_pkg::REG_GAIN_SEVEN: cfg_d.gain[6] = pwdata[ltcs_pkg::GAIN_W-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ltcs_pkg::REG_BIAS:
        prdata = ltcs_pkg::DATA_W'(cfg_q.bias);
      ltcs_pkg::REG_GAIN_ONE, ltcs_pkg::REG_GAIN_TWO, ltcs_pkg::REG_GAIN_THREE,
      ltcs_pkg::REG_GAIN_FOUR, ltcs_pkg::REG_GAIN_FIVE, ltcs_pkg::REG_GAIN_SIX,
      ltcs_pkg::REG_GAIN_SEVEN:
        prdata = ltcs_pkg::DATA_W'($signed(cfg_q.gain[idx - ltcs_pkg::REG_GAIN_ONE]));
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/ltcs_cell.sv]
// One multiply-accumulate cell of the scoring chain: adds gain*temp of its
// channel to the running sum and hands sum and item on. Uses ltcs_pkg.
`timescale 1ns / 1ps

module ltcs_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic [ltcs_pkg::GAIN_W-1:0]        gain_i,
  input  logic                               valid_i,
  input  logic signed [ltcs_pkg::SUM_W-1:0]  sum_i,
  input  ltcs_pkg::item_t                    item_i,
  output logic                               valid_o,
  output logic signed [ltcs_pkg::SUM_W-1:0]  sum_o,
  output ltcs_pkg::item_t                    item_o
);

  logic                                      valid_q;
  logic signed [ltcs_pkg::SUM_W-1:0]         sum_q, sum_d;
  ltcs_pkg::item_t                           item_q;
  logic signed [ltcs_pkg::PROD_W-1:0]        prod;

  assign prod  = ltcs_pkg::PROD_W'($signed(gain_i))
               * ltcs_pkg::PROD_W'($signed({1'b0, item_i.temp[IDX]}));
  assign sum_d = sum_i + {{(ltcs_pkg::SUM_W - ltcs_pkg::PROD_W){prod[ltcs_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // payload moves only with a live beat
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      sum_q  <= sum_d;
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign item_o  = item_q;

endmodule

[rtl/ltcs_tally.sv]
// Tail of the chain: thresholds the sum and keeps the saturating confusion
// tallies; on the last item it snapshots and clears them. Uses ltcs_pkg.
`timescale 1ns / 1ps

module ltcs_tally #(
  parameter int COUNT_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               valid_i,
  input  logic signed [ltcs_pkg::SUM_W-1:0]  sum_i,
  input  logic                               ice_i,
  input  logic                               last_i,
  output logic                               valid_o,
  output logic [1:0]                         decision_o,
  output logic                               last_o,
  output logic [4:0][ltcs_pkg::OUT_CNT_W-1:0] cnt_o,
  output logic [COUNT_BITS:0]                correct_o,
  output logic [COUNT_BITS:0]                wrong_o
);

  localparam int WideW = (COUNT_BITS > ltcs_pkg::OUT_CNT_W) ? COUNT_BITS
                                                            : ltcs_pkg::OUT_CNT_W;
  localparam logic signed [ltcs_pkg::SUM_W-1:0] LimPos = ltcs_pkg::SUM_W'(ltcs_pkg::ICE_LIMIT);
  localparam logic signed [ltcs_pkg::SUM_W-1:0] LimNeg = -LimPos;
  localparam logic [WideW-1:0] OutMax = {{(WideW - ltcs_pkg::OUT_CNT_W){1'b0}},
                                         {ltcs_pkg::OUT_CNT_W{1'b1}}};

  // tally order: ice_correct, ice_missed, water_correct, false_ice, items
  logic [4:0][COUNT_BITS-1:0]          tally_q, tally_d, tally_n;
  logic                                valid_q;
  logic [1:0]                          decision_q;
  logic                                last_q;
  logic [4:0][ltcs_pkg::OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS:0]                 correct_q, correct_d, wrong_q, wrong_d;
  ltcs_pkg::decision_e                 dec;
  logic [4:0]                          bump;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] t);
    sat_inc = (t == {COUNT_BITS{1'b1}}) ? t : t + 1'b1;
  endfunction

  function automatic logic [ltcs_pkg::OUT_CNT_W-1:0] clamp(input logic [COUNT_BITS-1:0] t);
    logic [WideW-1:0] w;
    w     = WideW'(t);
    clamp = (w > OutMax) ? ltcs_pkg::OUT_CNT_W'(OutMax) : ltcs_pkg::OUT_CNT_W'(w);
  endfunction

  always_comb begin
    if (sum_i > LimPos) begin
      dec = ltcs_pkg::DEC_ICE;
    end else if (sum_i < LimNeg) begin
      dec = ltcs_pkg::DEC_WATER;
    end else begin
      dec = ltcs_pkg::DEC_UNSURE;
    end
    bump    = '0;
    bump[0] = (dec == ltcs_pkg::DEC_ICE)   &&  ice_i;
    bump[1] = (dec == ltcs_pkg::DEC_WATER) &&  ice_i;
    bump[2] = (dec == ltcs_pkg::DEC_WATER) && !ice_i;
    bump[3] = (dec == ltcs_pkg::DEC_ICE)   && !ice_i;
    bump[4] = 1'b1;
    for (int k = 0; k < 5; k++) begin
      tally_n[k] = bump[k] ? sat_inc(tally_q[k]) : tally_q[k];
    end
    tally_d   = last_i ? '0 : tally_n;
    cnt_d     = '0;
    correct_d = '0;
    wrong_d   = '0;
    if (last_i) begin
      for (int k = 0; k < 5; k++) begin
        cnt_d[k] = clamp(tally_n[k]);
      end
      correct_d = {1'b0, tally_n[0]} + {1'b0, tally_n[2]};
      wrong_d   = {1'b0, tally_n[1]} + {1'b0, tally_n[3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tally_q <= '0;
    end else if (adv_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        tally_q <= tally_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      decision_q <= dec;
      last_q     <= last_i;
      cnt_q      <= cnt_d;
      correct_q  <= correct_d;
      wrong_q    <= wrong_d;
    end
  end

  assign valid_o    = valid_q;
  assign decision_o = decision_q;
  assign last_o     = last_q;
  assign cnt_o      = cnt_q;
  assign correct_o  = correct_q;
  assign wrong_o    = wrong_q;

endmodule

[rtl/ltcs_score.sv]
// Output stage: forms correct minus ten times wrong, saturates it to the
// result width and holds the result beat. Uses ltcs_pkg.
`timescale 1ns / 1ps

module ltcs_score #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  logic [1:0]                           decision_i,
  input  logic                                 last_i,
  input  logic [4:0][ltcs_pkg::OUT_CNT_W-1:0]  cnt_i,
  input  logic [COUNT_BITS:0]                  correct_i,
  input  logic [COUNT_BITS:0]                  wrong_i,
  output logic                                 valid_o,
  output logic [1:0]                           decision_o,
  output logic [4:0][ltcs_pkg::OUT_CNT_W-1:0]  cnt_o,
  output logic signed [ltcs_pkg::NUM_W-1:0]    num_o,
  output logic                                 tallies_valid_o
);

  localparam int NumW = COUNT_BITS + 6;
  localparam int ExtW = ((NumW > ltcs_pkg::NUM_W) ? NumW : ltcs_pkg::NUM_W) + 1;
  localparam logic signed [ExtW-1:0] SatHi = ExtW'(ltcs_pkg::NUM_MAX);
  localparam logic signed [ExtW-1:0] SatLo = ExtW'(ltcs_pkg::NUM_MIN);

  logic                                 valid_q;
  logic [1:0]                           decision_q;
  logic [4:0][ltcs_pkg::OUT_CNT_W-1:0]  cnt_q;
  logic signed [ltcs_pkg::NUM_W-1:0]    num_q, num_d;
  logic                                 tv_q;
  logic [COUNT_BITS+4:0]                wrong10;
  logic signed [ExtW-1:0]               num_ext;

  // times ten as eight plus two
  assign wrong10 = {1'b0, wrong_i, 3'b000} + {3'b000, wrong_i, 1'b0};
  assign num_ext = $signed(ExtW'(correct_i)) - $signed(ExtW'(wrong10));

  always_comb begin
    if (num_ext > SatHi) begin
      num_d = ltcs_pkg::NUM_W'(SatHi);
    end else if (num_ext < SatLo) begin
      num_d = ltcs_pkg::NUM_W'(SatLo);
    end else begin
      num_d = ltcs_pkg::NUM_W'(num_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      decision_q <= decision_i;
      cnt_q      <= cnt_i;
      num_q      <= num_d;
      tv_q       <= last_i;
    end
  end

  assign valid_o         = valid_q;
  assign decision_o      = decision_q;
  assign cnt_o           = cnt_q;
  assign num_o           = num_q;
  assign tallies_valid_o = tv_q;

endmodule

[rtl/ltcs_checker.sv]
// Port-level checker for the classifier scorer, bound to the top level.
// Depends on ltcs_pkg for field widths.
`timescale 1ns / 1ps

module ltcs_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  logic [1:0]                         decision_o,
  input  logic [ltcs_pkg::OUT_CNT_W-1:0]     ice_correct_o,
  input  logic [ltcs_pkg::OUT_CNT_W-1:0]     ice_missed_o,
  input  logic [ltcs_pkg::OUT_CNT_W-1:0]     water_correct_o,
  input  logic [ltcs_pkg::OUT_CNT_W-1:0]     false_ice_o,
  input  logic [ltcs_pkg::OUT_CNT_W-1:0]     item_total_o,
  input  logic signed [ltcs_pkg::NUM_W-1:0]  score_numerator_o,
  input  logic                               tallies_valid_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(decision_o)
      && $stable(item_total_o) && $stable(score_numerator_o) && $stable(tallies_valid_o))
    else $error("result beat changed while stalled");

  // the edge that sees reset low has cleared the flag by the next one
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  a_mid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tallies_valid_o |-> ice_correct_o == '0 && ice_missed_o == '0
      && water_correct_o == '0 && false_ice_o == '0 && item_total_o == '0
      && score_numerator_o == '0)
    else $error("tallies shown on a beat that does not close an evaluation");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tallies_valid_o |-> item_total_o != '0
      && ice_correct_o <= item_total_o && ice_missed_o <= item_total_o
      && water_correct_o <= item_total_o && false_ice_o <= item_total_o)
    else $error("a tally exceeds the item count");

endmodule

bind linear_threshold_classifier_scorer_top ltcs_checker u_ltcs_checker (.*);
